### design/gh_pkg.sv
// Shared types, constants and the base32 alphabet for the geohash encoder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package gh_pkg;

    localparam int COORD_W          = 33;
    localparam int CHAR_W           = 4;
    localparam int SYM_W            = 5;
    localparam int CODE_W           = 7;
    localparam int AXIS_W           = 32;
    localparam int MAX_CHARS_DEF    = 12;
    localparam int CHAR_COUNT_RESET = 9;
    localparam int QUEUE_DEPTH      = 2;
    localparam int S_TDATA_W        = 72;
    localparam int M_TDATA_W        = 16;

    // Queue status seen by the front and back ends.
    typedef struct packed {
        logic full;
        logic valid;
    } t_q_stat;

    // Maps a symbol to its character in "0123456789bcdefghjkmnpqrstuvwxyz".
    function automatic logic [CODE_W-1:0] gh_ascii(input logic [SYM_W-1:0] sym);
        logic [CODE_W-1:0] code;
        unique case (sym)
            5'd0:  code = 7'h30;
            5'd1:  code = 7'h31;
            5'd2:  code = 7'h32;
            5'd3:  code = 7'h33;
            5'd4:  code = 7'h34;
            5'd5:  code = 7'h35;
            5'd6:  code = 7'h36;
            5'd7:  code = 7'h37;
            5'd8:  code = 7'h38;
            5'd9:  code = 7'h39;
            5'd10: code = 7'h62;
            5'd11: code = 7'h63;
            5'd12: code = 7'h64;
            5'd13: code = 7'h65;
            5'd14: code = 7'h66;
            5'd15: code = 7'h67;
            5'd16: code = 7'h68;
            5'd17: code = 7'h6A;
            5'd18: code = 7'h6B;
            5'd19: code = 7'h6D;
            5'd20: code = 7'h6E;
            5'd21: code = 7'h70;
            5'd22: code = 7'h71;
            5'd23: code = 7'h72;
            5'd24: code = 7'h73;
            5'd25: code = 7'h74;
            5'd26: code = 7'h75;
            5'd27: code = 7'h76;
            5'd28: code = 7'h77;
            5'd29: code = 7'h78;
            5'd30: code = 7'h79;
            default: code = 7'h7A;
        endcase
        return code;
    endfunction

endpackage

### design/gh_front.sv
// Input side of the geohash encoder: takes coordinate transfers and turns them
// into the interleaved bisection bit string. Depends on gh_pkg.
`timescale 1ns / 1ps

module gh_front
    import gh_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF,
    parameter int NB        = SYM_W * MAX_CHARS
) (
    input  logic                     i_s_valid,
    output logic                     o_s_ready,
    input  logic signed [COORD_W-1:0] i_latitude,
    input  logic signed [COORD_W-1:0] i_longitude,
    input  logic [CHAR_W-1:0]        i_char_count,
    input  t_q_stat                  i_q_stat,
    output logic                     o_push,
    output logic [NB+CHAR_W-1:0]     o_entry
);

    logic [AXIS_W-1:0] lat_u;
    logic [AXIS_W-1:0] lon_u;
    logic [NB-1:0]     bits;

    // Bisection over (-2^31, 2^31] with "greater than midpoint" is the plain
    // binary expansion of x - 1 + 2^31, saturated to 32 bits at both ends.
    function automatic logic [AXIS_W-1:0] axis_code(input logic signed [COORD_W-1:0] x);
        logic signed [COORD_W:0] u;
        logic [AXIS_W-1:0]       res;
        u = {x[COORD_W-1], x} + (COORD_W+1)'((64'd1 << (AXIS_W-1)) - 64'd1);
        if (u[COORD_W]) begin
            res = '0;
        end else if (u[AXIS_W]) begin
            res = '1;
        end else begin
            res = u[AXIS_W-1:0];
        end
        return res;
    endfunction

    assign lat_u = axis_code(i_latitude);
    assign lon_u = axis_code(i_longitude);

    // Stream bit i (first bit at the top): even i from longitude, odd from latitude.
    always_comb begin
        for (int i = 0; i < NB; i++) begin
            if ((i % 2) == 0) begin
                bits[NB-1-i] = lon_u[AXIS_W-1-(i/2)];
            end else begin
                bits[NB-1-i] = lat_u[AXIS_W-1-(i/2)];
            end
        end
    end

    assign o_s_ready = !i_q_stat.full;
    assign o_push    = i_s_valid && !i_q_stat.full;
    assign o_entry   = {i_char_count, bits};

endmodule

### design/gh_queue.sv
// Short queue between the front and back ends of the geohash encoder.
// Depends on gh_pkg for the status struct.
`timescale 1ns / 1ps

module gh_queue
    import gh_pkg::*;
#(
    parameter int WIDTH = 64,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        if (p == PTR_W'(DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + PTR_W'(1);
        end
        return q;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_W'(DEPTH));
    assign o_stat.valid = (r_count != '0);

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != CNT_W'(DEPTH)))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue read while empty");
`endif

endmodule

### design/gh_back.sv
// Output side of the geohash encoder: walks one bit string five bits at a time
// and drives the registered character stream. Depends on gh_pkg.
`timescale 1ns / 1ps

module gh_back
    import gh_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF,
    parameter int NB        = SYM_W * MAX_CHARS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_q_stat              i_q_stat,
    input  logic [NB+CHAR_W-1:0] i_entry,
    output logic                 o_pop,
    output logic                 o_m_valid,
    input  logic                 i_m_ready,
    output logic [CODE_W-1:0]    o_char_code,
    output logic [SYM_W-1:0]     o_symbol,
    output logic                 o_last_char
);

    logic              r_active;
    logic [NB-1:0]     r_bits;
    logic [CHAR_W-1:0] r_left;
    logic              r_ov;
    logic [CODE_W-1:0] r_code;
    logic [SYM_W-1:0]  r_sym;
    logic              r_last;

    logic              n_active;
    logic [NB-1:0]     n_bits;
    logic [CHAR_W-1:0] n_left;

    logic              load_out;
    logic              emit;
    logic              emit_last;
    logic [SYM_W-1:0]  cur_sym;

    assign load_out  = !r_ov || i_m_ready;
    assign emit      = r_active && load_out;
    assign emit_last = emit && (r_left == CHAR_W'(1));
    assign cur_sym   = r_bits[NB-1 -: SYM_W];
    assign o_pop     = i_q_stat.valid && (!r_active || emit_last);

    always_comb begin
        n_active = r_active;
        n_bits   = r_bits;
        n_left   = r_left;
        if (emit) begin
            n_bits = r_bits << SYM_W;
            n_left = r_left - CHAR_W'(1);
            if (emit_last) begin
                n_active = 1'b0;
            end
        end
        if (o_pop) begin
            n_active = 1'b1;
            n_bits   = i_entry[NB-1:0];
            n_left   = i_entry[NB+CHAR_W-1:NB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_left   <= '0;
            r_ov     <= 1'b0;
        end else begin
            r_active <= n_active;
            r_left   <= n_left;
            if (load_out) begin
                r_ov <= r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_bits <= n_bits;
        if (emit) begin
            r_sym  <= cur_sym;
            r_code <= gh_ascii(cur_sym);
            r_last <= (r_left == CHAR_W'(1));
        end
    end

    assign o_m_valid   = r_ov;
    assign o_char_code = r_code;
    assign o_symbol    = r_sym;
    assign o_last_char = r_last;

`ifndef ASSERT_OFF
    a_left_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_left != '0) && (r_left <= CHAR_W'(MAX_CHARS)))
        else $error("character count out of range while busy");
    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_last && !i_q_stat.valid) |=> !r_active)
        else $error("still busy after the final character");
    a_last_marks_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit_last |=> (r_ov && r_last))
        else $error("final character not flagged as last");
`endif

endmodule

### design/geohash_encoder.sv
// Top level of the geohash encoder: configuration register, front end, queue
// and back end. Depends on gh_pkg, gh_front, gh_queue and gh_back.
`timescale 1ns / 1ps

// Each coordinate transfer yields char_count geohash characters (1 to
// MAX_CHARS, reset 9), one per cycle on the output stream while it is
// ready, the last one flagged by tlast. The output side sets the rate, with
// no gap between the characters of successive items while the queue holds
// the next one. The input side computes the whole bit string in the cycle of
// the transfer and parks it in a two-entry queue, so new coordinates are
// taken while the output is still draining or stalled. The first character
// passes through the queue, the back end's bit register and its output
// register before it is presented. Writes to char_count are clamped to
// 1..MAX_CHARS and must only be made while no item is in flight.

module geohash_encoder
    import gh_pkg::*;
#(
    parameter int MAX_CHARS = MAX_CHARS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CHAR_W-1:0]    i_cfg_wr_data,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // [32:0] latitude, [65:33] longitude, [71:66] zero
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // [6:0] char_code, [11:7] symbol, [15:12] zero
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic                 o_m_axis_tlast
);

    localparam int NB = SYM_W * MAX_CHARS;
    localparam int CC_RESET = (CHAR_COUNT_RESET > MAX_CHARS) ? MAX_CHARS : CHAR_COUNT_RESET;

    logic [CHAR_W-1:0]    r_char_count;
    t_q_stat              q_stat;
    logic                 push;
    logic                 pop;
    logic [NB+CHAR_W-1:0] push_entry;
    logic [NB+CHAR_W-1:0] pop_entry;
    logic [CODE_W-1:0]    char_code;
    logic [SYM_W-1:0]     symbol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_count <= CHAR_W'(CC_RESET);
        end else if (i_cfg_wr_en) begin
            if (i_cfg_wr_data == '0) begin
                r_char_count <= CHAR_W'(1);
            end else if (i_cfg_wr_data > CHAR_W'(MAX_CHARS)) begin
                r_char_count <= CHAR_W'(MAX_CHARS);
            end else begin
                r_char_count <= i_cfg_wr_data;
            end
        end
    end

    gh_front #(
        .MAX_CHARS (MAX_CHARS),
        .NB        (NB)
    ) u_front (
        .i_s_valid    (i_s_axis_tvalid),
        .o_s_ready    (o_s_axis_tready),
        .i_latitude   (i_s_axis_tdata[COORD_W-1:0]),
        .i_longitude  (i_s_axis_tdata[2*COORD_W-1:COORD_W]),
        .i_char_count (r_char_count),
        .i_q_stat     (q_stat),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    gh_queue #(
        .WIDTH (NB + CHAR_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_entry),
        .i_pop   (pop),
        .o_data  (pop_entry),
        .o_stat  (q_stat)
    );

    gh_back #(
        .MAX_CHARS (MAX_CHARS),
        .NB        (NB)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_stat    (q_stat),
        .i_entry     (pop_entry),
        .o_pop       (pop),
        .o_m_valid   (o_m_axis_tvalid),
        .i_m_ready   (i_m_axis_tready),
        .o_char_code (char_code),
        .o_symbol    (symbol),
        .o_last_char (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {(M_TDATA_W-CODE_W-SYM_W)'(0), symbol, char_code};

endmodule
